// ===== rtl/core/ilp_pkg.sv =====
// types, codes and character constants for the integer literal parser
// no dependencies; used by integer_literal_parser_top and its checker
package ilp_pkg;

    // input beat: one character of the token
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_beat_t;

    // result beat: value and status of one token
    typedef struct packed {
        logic signed [63:0] value;
        logic [2:0]         status;
    } result_beat_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_LZERO  = 3'd2,
        ST_LETTER = 3'd3,
        ST_PREFIX = 3'd4,
        ST_BADHEX = 3'd5,
        ST_BADBIN = 3'd6,
        ST_BADOCT = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        MODE_DEC  = 3'd0,
        MODE_HEX  = 3'd1,
        MODE_BIN  = 3'd2,
        MODE_OCT  = 3'd3,
        MODE_STOP = 3'd4,
        MODE_ERR  = 3'd5
    } mode_t;

    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_ONE        = 8'h31;
    localparam logic [7:0] CHAR_SEVEN      = 8'h37;
    localparam logic [7:0] CHAR_NINE       = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F    = 8'h66;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F    = 8'h46;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_X    = 8'h78;
    localparam logic [7:0] CHAR_LOWER_B    = 8'h62;
    localparam logic [7:0] CHAR_LOWER_O    = 8'h6F;

    // raw character positions, counted with saturation at two
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_LATER  = 2'd2;

endpackage

// ===== rtl/core/integer_literal_parser_top.sv =====
// integer literal parser: top level, the whole datapath
// depends on ilp_pkg (beat types, status and mode codes, character constants)

// Takes one character of an integer literal per beat on the char channel and,
// on the beat flagged last_char, delivers one result beat holding the 64-bit
// wrapping value and a 3-bit status. Underscores are skipped, the prefixes
// 0x, 0b and 0o select radix 16, 2 and 8, anything else is decimal. One
// character is taken every cycle with no gaps between tokens; a result beat
// is registered after its last character is accepted. The rate is set
// by the parse-state update, whose only arithmetic is one shift-and-add
// accumulate of the 64-bit value per character. The input register keeps
// taking characters while a result waits in the output register; only a
// second token end arriving behind an unread result stalls the char channel.
module integer_literal_parser_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_stall,
    input  ilp_pkg::char_beat_t   char_data,
    output logic                  result_valid,
    input  logic                  result_stall,
    output ilp_pkg::result_beat_t result_data
);

    // input register
    logic                in_valid_reg;
    ilp_pkg::char_beat_t in_beat_reg;

    // parse state
    ilp_pkg::mode_t   mode_reg, mode_next;
    logic [1:0]       pos_reg, pos_next;
    logic             lzero_reg, lzero_next;
    logic [63:0]      acc_reg, acc_next;
    ilp_pkg::status_t err_reg, err_next;
    logic             any_reg, any_next;

    // output register
    logic                  out_valid_reg;
    ilp_pkg::result_beat_t out_beat_reg, out_beat_next;

    logic       advance;
    logic [7:0] c;
    logic       is_us, is_dig, is_letter, is_hex_lo, is_hex_up;
    logic       lzero_eff;
    logic [3:0] dig_val;

    // the input stage moves on unless it holds a token end and the output is blocked
    assign advance = in_valid_reg && !(in_beat_reg.last_char && out_valid_reg && result_stall);
    assign char_stall = in_valid_reg && !advance;

    assign c         = in_beat_reg.char_code;
    assign is_us     = (c == ilp_pkg::CHAR_UNDERSCORE);
    assign is_dig    = (c >= ilp_pkg::CHAR_ZERO) && (c <= ilp_pkg::CHAR_NINE);
    assign is_hex_lo = (c >= ilp_pkg::CHAR_LOWER_A) && (c <= ilp_pkg::CHAR_LOWER_F);
    assign is_hex_up = (c >= ilp_pkg::CHAR_UPPER_A) && (c <= ilp_pkg::CHAR_UPPER_F);
    assign is_letter = ((c >= ilp_pkg::CHAR_LOWER_A) && (c <= ilp_pkg::CHAR_LOWER_Z))
                    || ((c >= ilp_pkg::CHAR_UPPER_A) && (c <= ilp_pkg::CHAR_UPPER_Z));

    // digit value: low nibble for 0-9, low nibble plus nine for a-f / A-F
    assign dig_val = is_dig ? c[3:0] : 4'(c[3:0] + 4'd9);

    // leading-zero flag as seen by this character
    assign lzero_eff = (pos_reg == ilp_pkg::POS_FIRST) ? (c == ilp_pkg::CHAR_ZERO) : lzero_reg;

    // next parse state
    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        lzero_next = lzero_reg;
        acc_next   = acc_reg;
        err_next   = err_reg;
        any_next   = any_reg;

        unique case (mode_reg) inside
            ilp_pkg::MODE_DEC:
            begin
                if (!is_us)
                begin
                    lzero_next = lzero_eff;
                    if (lzero_eff && (pos_reg == ilp_pkg::POS_SECOND) && is_dig)
                    begin
                        mode_next = ilp_pkg::MODE_ERR;
                        err_next  = ilp_pkg::ST_LZERO;
                    end
                    else if (is_letter)
                    begin
                        any_next = 1'b0;
                        if (!(lzero_eff && (pos_reg == ilp_pkg::POS_SECOND)))
                        begin
                            mode_next = ilp_pkg::MODE_ERR;
                            err_next  = ilp_pkg::ST_LETTER;
                        end
                        else if (c == ilp_pkg::CHAR_LOWER_X)
                            mode_next = ilp_pkg::MODE_HEX;
                        else if (c == ilp_pkg::CHAR_LOWER_B)
                            mode_next = ilp_pkg::MODE_BIN;
                        else if (c == ilp_pkg::CHAR_LOWER_O)
                            mode_next = ilp_pkg::MODE_OCT;
                        else
                        begin
                            mode_next = ilp_pkg::MODE_ERR;
                            err_next  = ilp_pkg::ST_PREFIX;
                        end
                    end
                    else if (!is_dig)
                    begin
                        if (pos_reg == ilp_pkg::POS_FIRST)
                        begin
                            mode_next = ilp_pkg::MODE_ERR;
                            err_next  = ilp_pkg::ST_EMPTY;
                        end
                        else
                            mode_next = ilp_pkg::MODE_STOP;
                    end
                    else
                        // times ten as eight plus two
                        acc_next = (acc_reg << 3) + (acc_reg << 1) + {60'd0, dig_val};
                end
                if (pos_reg != ilp_pkg::POS_LATER)
                    pos_next = 2'(pos_reg + 2'd1);
            end
            ilp_pkg::MODE_HEX:
            begin
                any_next = 1'b1;
                if (!is_us)
                begin
                    if (is_dig || is_hex_lo || is_hex_up)
                        acc_next = {acc_reg[59:0], dig_val};
                    else
                    begin
                        mode_next = ilp_pkg::MODE_ERR;
                        err_next  = ilp_pkg::ST_BADHEX;
                    end
                end
            end
            ilp_pkg::MODE_BIN:
            begin
                any_next = 1'b1;
                if (!is_us)
                begin
                    if ((c == ilp_pkg::CHAR_ZERO) || (c == ilp_pkg::CHAR_ONE))
                        acc_next = {acc_reg[62:0], c[0]};
                    else
                    begin
                        mode_next = ilp_pkg::MODE_ERR;
                        err_next  = ilp_pkg::ST_BADBIN;
                    end
                end
            end
            ilp_pkg::MODE_OCT:
            begin
                any_next = 1'b1;
                if (!is_us)
                begin
                    if ((c >= ilp_pkg::CHAR_ZERO) && (c <= ilp_pkg::CHAR_SEVEN))
                        acc_next = {acc_reg[60:0], c[2:0]};
                    else
                    begin
                        mode_next = ilp_pkg::MODE_ERR;
                        err_next  = ilp_pkg::ST_BADOCT;
                    end
                end
            end
            ilp_pkg::MODE_STOP,
            ilp_pkg::MODE_ERR:
            begin
                // rest of the token is ignored
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // result beat from the state this character leaves behind
    always_comb
    begin
        out_beat_next.value  = 64'sd0;
        out_beat_next.status = ilp_pkg::ST_OK;
        if (mode_next == ilp_pkg::MODE_ERR)
            out_beat_next.status = err_next;
        else if (((mode_next == ilp_pkg::MODE_HEX) || (mode_next == ilp_pkg::MODE_BIN)
                  || (mode_next == ilp_pkg::MODE_OCT)) && !any_next)
            out_beat_next.status = ilp_pkg::ST_EMPTY;
        else
            out_beat_next.value = $signed(acc_next);
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!char_stall)
            in_valid_reg <= char_valid;
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
            in_beat_reg <= char_data;
    end

    // parse state: back to start of token after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ilp_pkg::MODE_DEC;
            pos_reg   <= ilp_pkg::POS_FIRST;
            lzero_reg <= 1'b0;
            acc_reg   <= 64'd0;
            err_reg   <= ilp_pkg::ST_OK;
            any_reg   <= 1'b0;
        end
        else if (advance)
        begin
            if (in_beat_reg.last_char)
            begin
                mode_reg  <= ilp_pkg::MODE_DEC;
                pos_reg   <= ilp_pkg::POS_FIRST;
                lzero_reg <= 1'b0;
                acc_reg   <= 64'd0;
                err_reg   <= ilp_pkg::ST_OK;
                any_reg   <= 1'b0;
            end
            else
            begin
                mode_reg  <= mode_next;
                pos_reg   <= pos_next;
                lzero_reg <= lzero_next;
                acc_reg   <= acc_next;
                err_reg   <= err_next;
                any_reg   <= any_next;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_beat_reg.last_char)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_beat_reg.last_char)
            out_beat_reg <= out_beat_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_beat_reg;

endmodule

// ===== rtl/core/ilp_checker.sv =====
// port-level checks for the integer literal parser
// depends on ilp_pkg; bound to integer_literal_parser_top below
module ilp_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  char_valid,
    input logic                  char_stall,
    input ilp_pkg::char_beat_t   char_data,
    input logic                  result_valid,
    input logic                  result_stall,
    input ilp_pkg::result_beat_t result_data
);

    // an error or empty status never carries a value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.status != ilp_pkg::ST_OK) |-> result_data.value == 64'sd0)
    else $error("nonzero value with error status");

    // char side only stalls behind a blocked result
    assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> result_valid && result_stall)
    else $error("char stall without result back-pressure");

    // a stall lasts until the result is drained, then clears
    assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |=> (char_stall == result_stall))
    else $error("char stall outlived result back-pressure");

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
    else $error("stalled result beat changed");

    // stalled char beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> char_valid && $stable(char_data))
    else $error("stalled char beat changed");

endmodule

bind integer_literal_parser_top ilp_checker u_ilp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_data    (char_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);

// ===== verif/testbench.sv =====
// checker for integer_literal_parser_top: feeds literal characters, predicts each token result
// depends on ilp_pkg (beat types, status and mode codes, character constants) and the rtl top
`timescale 1ns / 100ps

module testbench;

    // run length and limits
    localparam int RANDOM_CHARS = 1900;  // random characters, split over four idling phases
    localparam int PHASES       = 4;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off to fill the pipeline
    localparam int DRAIN_CYCLES = 10;    // quiet cycles once every expected result has come out
    localparam int CYCLE_LIMIT  = 200000;

    // one line of the directed table: a character, its end flag and, where it can be
    // read straight off the spec, the result that token must give
    typedef struct {
        logic [7:0]       ch;
        logic             last;
        logic             typed;
        logic [63:0]      value;
        ilp_pkg::status_t status;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  char_valid   = 1'b0;
    ilp_pkg::char_beat_t   char_data    = '0;
    logic                  char_stall;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    ilp_pkg::result_beat_t result_data;

    // idling controls: sender side is read by the stimulus process only,
    // receiver side is updated with nonblocking writes
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    logic         pressure_start = 1'b0;

    // bookkeeping
    ilp_pkg::result_beat_t pending_literals [$];  // expected token results, oldest first
    int           error_count      = 0;
    int           results_checked  = 0;
    int           chars_sent       = 0;
    int           backpressure_cyc = 0;
    int           cycle_count      = 0;
    int           hold_count       = 0;
    logic         hold_done        = 1'b0;

    // shadow of the parser state
    ilp_pkg::mode_t   lit_mode;
    logic [1:0]       lit_pos;
    logic             lit_lzero;
    logic [63:0]      lit_acc;
    ilp_pkg::status_t lit_err;
    logic             lit_seen;

    // directed table: every status code, the empty and underscore-only runs after a
    // prefix, a leading underscore, a non-digit that stops accumulation, and chars
    // at both ends of the 8-bit range
    dir_row_t directed_rows [25] = '{
        '{"_",   1'b1, 1'b1, 64'd0, ilp_pkg::ST_OK},      // leading underscore is no leading zero
        '{"9",   1'b1, 1'b1, 64'd9, ilp_pkg::ST_OK},
        '{"0",   1'b0, 1'b0, 64'd0, ilp_pkg::ST_OK},
        '{"7",   1'b1, 1'b1, 64'd0, ilp_pkg::ST_LZERO},   // zero followed by a digit
        '{"a",   1'b1, 1'b1, 64'd0, ilp_pkg::ST_LETTER},  // letter outside the prefix slot
        '{"0",   1'b0, 1'b0, 64'd0, ilp_pkg::ST_OK},
        '{"q",   1'b1, 1'b1, 64'd0, ilp_pkg::ST_PREFIX},  // unknown prefix letter
        '{"0",   1'b0, 1'b0, 64'd0, ilp_pkg::ST_OK},
        '{"x",   1'b0, 1'b0, 64'd0, ilp_pkg::ST_OK},
        '{"g",   1'b1, 1'b1, 64'd0, ilp_pkg::ST_BADHEX},
        '{"0",   1'b0, 1'b0, 64'd0, ilp_pkg::ST_OK},
        '{"b",   1'b0, 1'b0, 64'd0, ilp_pkg::ST_OK},
        '{"2",   1'b1, 1'b1, 64'd0, ilp_pkg::ST_BADBIN},
        '{"0",   1'b0, 1'b0, 64'd0, ilp_pkg::ST_OK},
        '{"o",   1'b0, 1'b0, 64'd0, ilp_pkg::ST_OK},
        '{"8",   1'b1, 1'b1, 64'd0, ilp_pkg::ST_BADOCT},
        '{".",   1'b1, 1'b1, 64'd0, ilp_pkg::ST_EMPTY},   // non-digit as the very first char
        '{"0",   1'b0, 1'b0, 64'd0, ilp_pkg::ST_OK},
        '{"x",   1'b1, 1'b1, 64'd0, ilp_pkg::ST_EMPTY},   // token ends right on the prefix
        '{"0",   1'b0, 1'b0, 64'd0, ilp_pkg::ST_OK},
        '{"b",   1'b0, 1'b0, 64'd0, ilp_pkg::ST_OK},
        '{"_",   1'b1, 1'b1, 64'd0, ilp_pkg::ST_OK},      // underscores alone count as a run
        '{8'hFF, 1'b1, 1'b1, 64'd0, ilp_pkg::ST_EMPTY},   // high chars: no digit, no letter
        '{"1",   1'b0, 1'b0, 64'd0, ilp_pkg::ST_OK},
        '{8'h00, 1'b1, 1'b0, 64'd0, ilp_pkg::ST_OK}       // stop char after a digit, value kept
    };

    integer_literal_parser_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // literal predictor
    // ------------------------------------------------------------------

    function automatic logic is_digit(logic [7:0] c);
        return c >= ilp_pkg::CHAR_ZERO && c <= ilp_pkg::CHAR_NINE;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= ilp_pkg::CHAR_LOWER_A && c <= ilp_pkg::CHAR_LOWER_Z) ||
               (c >= ilp_pkg::CHAR_UPPER_A && c <= ilp_pkg::CHAR_UPPER_Z);
    endfunction

    function automatic void clear_literal_state();
        lit_mode  = ilp_pkg::MODE_DEC;
        lit_pos   = ilp_pkg::POS_FIRST;
        lit_lzero = 1'b0;
        lit_acc   = '0;
        lit_err   = ilp_pkg::ST_OK;
        lit_seen  = 1'b0;
    endfunction

    function automatic void flag_error(ilp_pkg::status_t code);
        lit_mode = ilp_pkg::MODE_ERR;
        lit_err  = code;
    endfunction

    // advance the shadow state by one char; returns 1 with the token result on the last one
    function automatic logic parse_char(ilp_pkg::char_beat_t b,
                                        output ilp_pkg::result_beat_t res);
        logic [7:0] c;
        logic [3:0] nib;
        logic       good;
        c   = b.char_code;
        res = '0;
        if (lit_mode == ilp_pkg::MODE_DEC)
        begin
            if (c != ilp_pkg::CHAR_UNDERSCORE)
            begin
                if (lit_pos == ilp_pkg::POS_FIRST)
                    lit_lzero = (c == ilp_pkg::CHAR_ZERO);
                if (lit_lzero && lit_pos == ilp_pkg::POS_SECOND && is_digit(c))
                    flag_error(ilp_pkg::ST_LZERO);
                else if (is_alpha(c))
                begin
                    // only the slot right after a leading zero may hold a prefix letter
                    if (!(lit_lzero && lit_pos == ilp_pkg::POS_SECOND))
                        flag_error(ilp_pkg::ST_LETTER);
                    else if (c == ilp_pkg::CHAR_LOWER_X)
                        lit_mode = ilp_pkg::MODE_HEX;
                    else if (c == ilp_pkg::CHAR_LOWER_B)
                        lit_mode = ilp_pkg::MODE_BIN;
                    else if (c == ilp_pkg::CHAR_LOWER_O)
                        lit_mode = ilp_pkg::MODE_OCT;
                    else
                        flag_error(ilp_pkg::ST_PREFIX);
                    lit_seen = 1'b0;
                end
                else if (!is_digit(c))
                begin
                    if (lit_pos == ilp_pkg::POS_FIRST)
                        flag_error(ilp_pkg::ST_EMPTY);
                    else
                        lit_mode = ilp_pkg::MODE_STOP;
                end
                else
                    lit_acc = lit_acc * 64'd10 + 64'(c - ilp_pkg::CHAR_ZERO);
            end
            if (lit_pos != ilp_pkg::POS_LATER)
                lit_pos = lit_pos + 2'd1;
        end
        else if (lit_mode == ilp_pkg::MODE_HEX || lit_mode == ilp_pkg::MODE_BIN ||
                 lit_mode == ilp_pkg::MODE_OCT)
        begin
            lit_seen = 1'b1;
            if (c != ilp_pkg::CHAR_UNDERSCORE)
            begin
                good = 1'b1;
                nib  = 4'(c - ilp_pkg::CHAR_ZERO);
                case (lit_mode)
                    ilp_pkg::MODE_HEX:
                    begin
                        if (c >= ilp_pkg::CHAR_LOWER_A && c <= ilp_pkg::CHAR_LOWER_F)
                            nib = 4'(c - ilp_pkg::CHAR_LOWER_A + 8'd10);
                        else if (c >= ilp_pkg::CHAR_UPPER_A && c <= ilp_pkg::CHAR_UPPER_F)
                            nib = 4'(c - ilp_pkg::CHAR_UPPER_A + 8'd10);
                        else if (!is_digit(c))
                            good = 1'b0;
                        if (good)
                            lit_acc = {lit_acc[59:0], nib};
                        else
                            flag_error(ilp_pkg::ST_BADHEX);
                    end
                    ilp_pkg::MODE_BIN:
                    begin
                        if (c == ilp_pkg::CHAR_ZERO || c == ilp_pkg::CHAR_ONE)
                            lit_acc = {lit_acc[62:0], nib[0]};
                        else
                            flag_error(ilp_pkg::ST_BADBIN);
                    end
                    default:
                    begin
                        if (c >= ilp_pkg::CHAR_ZERO && c <= ilp_pkg::CHAR_SEVEN)
                            lit_acc = {lit_acc[60:0], nib[2:0]};
                        else
                            flag_error(ilp_pkg::ST_BADOCT);
                    end
                endcase
            end
        end
        // stop and error modes ignore the rest of the token

        if (!b.last_char)
            return 1'b0;
        if (lit_mode == ilp_pkg::MODE_ERR)
        begin
            res.value  = '0;
            res.status = lit_err;
        end
        else if ((lit_mode == ilp_pkg::MODE_HEX || lit_mode == ilp_pkg::MODE_BIN ||
                  lit_mode == ilp_pkg::MODE_OCT) && !lit_seen)
        begin
            res.value  = '0;
            res.status = ilp_pkg::ST_EMPTY;
        end
        else
        begin
            res.value  = lit_acc;
            res.status = ilp_pkg::ST_OK;
        end
        clear_literal_state();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // char channel driver
    // ------------------------------------------------------------------

    // offer one char until it is taken; on acceptance the expected result, if any,
    // is queued (the typed value from the table where the row gives one)
    task automatic send_beat(logic [7:0] ch, logic last, logic typed,
                             ilp_pkg::result_beat_t typed_res);
        ilp_pkg::char_beat_t   beat;
        ilp_pkg::result_beat_t res;
        beat.char_code = ch;
        beat.last_char = last;
        // random gaps before the beat; geometric length so gaps land anywhere
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= beat;
        do
            @(posedge clk);
        while (char_stall);
        if (parse_char(beat, res))
            pending_literals.push_back(typed ? typed_res : res);
    endtask

    // one digit of the given radix; top forces the largest digit to drive the
    // accumulator toward all ones and through the 64-bit wrap
    function automatic logic [7:0] pick_digit(ilp_pkg::mode_t radix, logic top, logic lead);
        int r;
        case (radix)
            ilp_pkg::MODE_HEX:
            begin
                r = $urandom_range(21);
                if (top)
                    return ilp_pkg::CHAR_LOWER_F;
                if (r < 10)
                    return ilp_pkg::CHAR_ZERO + 8'(r);
                if (r < 16)
                    return ilp_pkg::CHAR_LOWER_A + 8'(r - 10);
                return ilp_pkg::CHAR_UPPER_A + 8'(r - 16);
            end
            ilp_pkg::MODE_BIN:
                return top ? ilp_pkg::CHAR_ONE : ilp_pkg::CHAR_ZERO + 8'($urandom_range(1));
            ilp_pkg::MODE_OCT:
                return top ? ilp_pkg::CHAR_SEVEN : ilp_pkg::CHAR_ZERO + 8'($urandom_range(7));
            default:
            begin
                // a decimal token mostly avoids a leading zero, but not always
                if (top)
                    return ilp_pkg::CHAR_NINE;
                if (lead && $urandom_range(7) != 0)
                    return ilp_pkg::CHAR_ZERO + 8'($urandom_range(1, 9));
                return ilp_pkg::CHAR_ZERO + 8'($urandom_range(9));
            end
        endcase
    endfunction

    // one random token: mostly well-formed literals with random digits and
    // underscores, some with one char corrupted, the rest plain noise bytes
    task automatic send_random_literal();
        logic [7:0]     chars [$];
        ilp_pkg::mode_t radix;
        int             kind;
        int             ndigits;
        int             spot;
        logic           top;
        kind    = $urandom_range(99);
        ndigits = ($urandom_range(9) == 0) ? $urandom_range(14, 24) : $urandom_range(1, 6);
        top     = ($urandom_range(9) == 0);
        case ($urandom_range(3))
            0:       radix = ilp_pkg::MODE_DEC;
            1:       radix = ilp_pkg::MODE_HEX;
            2:       radix = ilp_pkg::MODE_BIN;
            default: radix = ilp_pkg::MODE_OCT;
        endcase
        if (radix != ilp_pkg::MODE_DEC)
        begin
            chars.push_back(ilp_pkg::CHAR_ZERO);
            chars.push_back(radix == ilp_pkg::MODE_HEX ? ilp_pkg::CHAR_LOWER_X :
                            radix == ilp_pkg::MODE_BIN ? ilp_pkg::CHAR_LOWER_B :
                                                         ilp_pkg::CHAR_LOWER_O);
        end
        for (int i = 0; i < ndigits; i++)
        begin
            if ($urandom_range(6) == 0)
                chars.push_back(ilp_pkg::CHAR_UNDERSCORE);
            chars.push_back(pick_digit(radix, top, i == 0));
        end
        if (kind >= 80)
        begin
            // noise token, any byte value
            chars.delete();
            repeat ($urandom_range(1, 5))
                chars.push_back(8'($urandom_range(255)));
        end
        else if (kind >= 62)
        begin
            // broken token: one char swapped for a random byte
            spot        = $urandom_range(chars.size() - 1);
            chars[spot] = 8'($urandom_range(255));
        end
        foreach (chars[i])
        begin
            send_beat(chars[i], i == chars.size() - 1, 1'b0, '0);
            chars_sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // result channel: checker and stall generator
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        ilp_pkg::result_beat_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                results_checked++;
                if (pending_literals.size() == 0)
                begin
                    $error("result beat with nothing expected: value %0d status %0d",
                           result_data.value, result_data.status);
                    error_count++;
                end
                else
                begin
                    want = pending_literals.pop_front();
                    if (result_data.value !== want.value)
                    begin
                        $error("value: expected %0d, got %0d", want.value, result_data.value);
                        error_count++;
                    end
                    if (result_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status,
                               result_data.status);
                        error_count++;
                    end
                end
            end
            // long hold-off once, while the sender keeps pushing, so the output
            // register fills and the char channel has to stall
            if (pressure_start && !hold_done)
            begin
                result_stall <= 1'b1;
                hold_count++;
                if (hold_count == HOLD_CYCLES)
                    hold_done = 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // cycle counter and watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (char_valid && char_stall)
            backpressure_cyc <= backpressure_cyc + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("watchdog expired after %0d cycles", CYCLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------

    initial
    begin
        ilp_pkg::result_beat_t typed_res;
        clear_literal_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling on either side
        foreach (directed_rows[i])
        begin
            typed_res.value  = directed_rows[i].value;
            typed_res.status = directed_rows[i].status;
            send_beat(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed,
                      typed_res);
        end

        // random tokens over the idling phases: none, sender gaps, receiver
        // stalls, both; the long hold-off falls in the first phase
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 0;
                    pressure_start <= 1'b1;
                end
                1:
                begin
                    send_idle_pct   = 63;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 63;
                end
                default:
                begin
                    send_idle_pct   = 18;
                    recv_stall_pct <= 18;
                end
            endcase
            while (chars_sent < RANDOM_CHARS * (ph + 1) / PHASES)
                send_random_literal();
        end
        char_valid <= 1'b0;

        // drain: everything expected must come out, then a few quiet cycles
        while (pending_literals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d directed and %0d random chars sent, %0d token results checked",
                 $size(directed_rows), chars_sent, results_checked);
        $display("char channel held off in %0d cycles, %0d mismatches",
                 backpressure_cyc, error_count);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ilp_pkg.sv
rtl/core/integer_literal_parser_top.sv
rtl/core/ilp_checker.sv
verif/testbench.sv
